[src/mkse_pkg.sv]
// ----------------------------------------------------------------------------
// mkse_pkg
// Types, constants and the character and speed tables of the morse keyer
// segment encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mkse_pkg;

  localparam int unsigned WpmW   = 6;
  localparam int unsigned DotW   = 11;
  localparam int unsigned DurW   = 14;
  localparam int unsigned PatW   = 6;
  localparam int unsigned LenW   = 3;

  localparam logic [WpmW-1:0] WpmMin   = 6'd1;
  localparam logic [WpmW-1:0] WpmMax   = 6'd40;
  localparam logic [WpmW-1:0] WpmReset = 6'd20;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChEnd   = 8'h00;

  typedef struct packed {
    logic [7:0] char_code;
    logic [7:0] next_code;
  } in_t;

  typedef struct packed {
    logic            key_level;
    logic [DurW-1:0] duration_ms;
    logic            last_segment;
  } out_t;

  // segment lengths for the current speed
  typedef struct packed {
    logic [DurW-1:0] dot1;
    logic [DurW-1:0] dot3;
    logic [DurW-1:0] dot7;
  } dur_t;

  // element pattern: first element at the msb, 1 is a dash
  typedef struct packed {
    logic            known;
    logic [LenW-1:0] len;
    logic [PatW-1:0] pat;
  } code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_GAP,
    ST_TAIL,
    ST_WORD
  } state_e;

  function automatic logic [DotW-1:0] dot_ms(input logic [WpmW-1:0] wpm);
    logic [DotW-1:0] r;
    unique case (wpm)
      6'd1:    r = 11'd1200;
      6'd2:    r = 11'd600;
      6'd3:    r = 11'd400;
      6'd4:    r = 11'd300;
      6'd5:    r = 11'd240;
      6'd6:    r = 11'd200;
      6'd7:    r = 11'd171;
      6'd8:    r = 11'd150;
      6'd9:    r = 11'd133;
      6'd10:   r = 11'd120;
      6'd11:   r = 11'd109;
      6'd12:   r = 11'd100;
      6'd13:   r = 11'd92;
      6'd14:   r = 11'd85;
      6'd15:   r = 11'd80;
      6'd16:   r = 11'd75;
      6'd17:   r = 11'd70;
      6'd18:   r = 11'd66;
      6'd19:   r = 11'd63;
      6'd20:   r = 11'd60;
      6'd21:   r = 11'd57;
      6'd22:   r = 11'd54;
      6'd23:   r = 11'd52;
      6'd24:   r = 11'd50;
      6'd25:   r = 11'd48;
      6'd26:   r = 11'd46;
      6'd27:   r = 11'd44;
      6'd28:   r = 11'd42;
      6'd29:   r = 11'd41;
      6'd30:   r = 11'd40;
      6'd31:   r = 11'd38;
      6'd32:   r = 11'd37;
      6'd33:   r = 11'd36;
      6'd34:   r = 11'd35;
      6'd35:   r = 11'd34;
      6'd36:   r = 11'd33;
      6'd37:   r = 11'd32;
      6'd38:   r = 11'd31;
      6'd39:   r = 11'd30;
      6'd40:   r = 11'd30;
      default: r = 11'd1200;
    endcase
    return r;
  endfunction

  function automatic code_t code_lookup(input logic [7:0] ch);
    logic [7:0] c;
    code_t      r;
    c = ch;
    if (ch >= 8'h61 && ch <= 8'h7a) begin
      c = ch - 8'd32;
    end
    r = '{known: 1'b1, len: 3'd0, pat: 6'b000000};
    unique case (c)
      "A":     begin r.len = 3'd2; r.pat = 6'b010000; end
      "B":     begin r.len = 3'd4; r.pat = 6'b100000; end
      "C":     begin r.len = 3'd4; r.pat = 6'b101000; end
      "D":     begin r.len = 3'd3; r.pat = 6'b100000; end
      "E":     begin r.len = 3'd1; r.pat = 6'b000000; end
      "F":     begin r.len = 3'd4; r.pat = 6'b001000; end
      "G":     begin r.len = 3'd3; r.pat = 6'b110000; end
      "H":     begin r.len = 3'd4; r.pat = 6'b000000; end
      "I":     begin r.len = 3'd2; r.pat = 6'b000000; end
      "J":     begin r.len = 3'd4; r.pat = 6'b011100; end
      "K":     begin r.len = 3'd3; r.pat = 6'b101000; end
      "L":     begin r.len = 3'd4; r.pat = 6'b010000; end
      "M":     begin r.len = 3'd2; r.pat = 6'b110000; end
      "N":     begin r.len = 3'd2; r.pat = 6'b100000; end
      "O":     begin r.len = 3'd3; r.pat = 6'b111000; end
      "P":     begin r.len = 3'd4; r.pat = 6'b011000; end
      "Q":     begin r.len = 3'd4; r.pat = 6'b110100; end
      "R":     begin r.len = 3'd3; r.pat = 6'b010000; end
      "S":     begin r.len = 3'd3; r.pat = 6'b000000; end
      "T":     begin r.len = 3'd1; r.pat = 6'b100000; end
      "U":     begin r.len = 3'd3; r.pat = 6'b001000; end
      "V":     begin r.len = 3'd4; r.pat = 6'b000100; end
      "W":     begin r.len = 3'd3; r.pat = 6'b011000; end
      "X":     begin r.len = 3'd4; r.pat = 6'b100100; end
      "Y":     begin r.len = 3'd4; r.pat = 6'b101100; end
      "Z":     begin r.len = 3'd4; r.pat = 6'b110000; end
      "0":     begin r.len = 3'd5; r.pat = 6'b111110; end
      "1":     begin r.len = 3'd5; r.pat = 6'b011110; end
      "2":     begin r.len = 3'd5; r.pat = 6'b001110; end
      "3":     begin r.len = 3'd5; r.pat = 6'b000110; end
      "4":     begin r.len = 3'd5; r.pat = 6'b000010; end
      "5":     begin r.len = 3'd5; r.pat = 6'b000000; end
      "6":     begin r.len = 3'd5; r.pat = 6'b100000; end
      "7":     begin r.len = 3'd5; r.pat = 6'b110000; end
      "8":     begin r.len = 3'd5; r.pat = 6'b111000; end
      "9":     begin r.len = 3'd5; r.pat = 6'b111100; end
      ".":     begin r.len = 3'd6; r.pat = 6'b010101; end
      ",":     begin r.len = 3'd6; r.pat = 6'b110011; end
      "?":     begin r.len = 3'd6; r.pat = 6'b001100; end
      "!":     begin r.len = 3'd6; r.pat = 6'b101011; end
      "/":     begin r.len = 3'd5; r.pat = 6'b100100; end
      "(":     begin r.len = 3'd5; r.pat = 6'b101100; end
      ")":     begin r.len = 3'd6; r.pat = 6'b101101; end
      "-":     begin r.len = 3'd6; r.pat = 6'b100001; end
      "=":     begin r.len = 3'd5; r.pat = 6'b100010; end
      "+":     begin r.len = 3'd5; r.pat = 6'b010100; end
      default: r.known = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[src/mkse_speed_reg.sv]
// ----------------------------------------------------------------------------
// mkse_speed_reg
// Speed register with write saturation; registers the dot length and derives
// the dash and word-gap lengths from it for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mkse_speed_reg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [5:0]            cfg_data_i,
  output mkse_pkg::dur_t             dur_o
);
  import mkse_pkg::*;

  logic [WpmW-1:0] wpm_sat;
  logic [DotW-1:0] dot_d, dot_q;
  logic [DurW-1:0] dot_ext;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    priority if (cfg_data_i < WpmMin) begin
      wpm_sat = WpmMin;
    end else if (cfg_data_i > WpmMax) begin
      wpm_sat = WpmMax;
    end else begin
      wpm_sat = cfg_data_i;
    end
  end

  assign dot_d = dot_ms(wpm_sat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= dot_ms(WpmReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      dot_q <= dot_d;
    end
  end

  assign dot_ext    = DurW'(dot_q);
  assign dur_o.dot1 = dot_ext;
  assign dur_o.dot3 = dot_ext + {dot_ext[DurW-2:0], 1'b0};
  assign dur_o.dot7 = {dot_ext[DurW-4:0], 3'b000} - dot_ext;

endmodule

`default_nettype wire

[src/morse_keyer_segment_encoder.sv]
// ----------------------------------------------------------------------------
// morse_keyer_segment_encoder
// Keys one character into tone and silence segments with ITU timing.
// ----------------------------------------------------------------------------
// first segment: sequencer state register, then output register
// throughput: one segment per cycle while the output is not stalled, up to
//   twelve per character; the next character is taken once the last is registered
// unknown characters are taken and give no segment
// reset: speed returns to 20 wpm, sequencer idle, output empty
`default_nettype none

module morse_keyer_segment_encoder (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire mkse_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output mkse_pkg::out_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [5:0]     cfg_data_i
);
  import mkse_pkg::*;

  dur_t            dur;
  code_t           code;
  state_e          state_d, state_q;
  logic [PatW-1:0] pat_d, pat_q;
  logic [LenW-1:0] cnt_d, cnt_q;
  logic            tail_d, tail_q;
  logic            out_valid_d, out_valid_q;
  out_t            out_d, out_q;
  logic            in_take;
  logic            slot_free;
  logic            emit;
  out_t            seg;

  mkse_speed_reg u_speed (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .dur_o      (dur)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign code       = code_lookup(in_data_i.char_code);

  // next state
  always_comb begin
    state_d = state_q;
    pat_d   = pat_q;
    cnt_d   = cnt_q;
    tail_d  = tail_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          pat_d  = code.pat;
          cnt_d  = code.len;
          tail_d = (in_data_i.next_code != ChEnd) && (in_data_i.next_code != ChSpace);
          priority if (in_data_i.char_code == ChSpace) begin
            state_d = ST_WORD;
          end else if (code.known) begin
            state_d = ST_MARK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MARK: begin
        if (slot_free) begin
          pat_d = {pat_q[PatW-2:0], 1'b0};
          cnt_d = cnt_q - 3'd1;
          priority if (cnt_q != 3'd1) begin
            state_d = ST_GAP;
          end else if (tail_q) begin
            state_d = ST_TAIL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_GAP: begin
        if (slot_free) begin
          state_d = ST_MARK;
        end
      end
      ST_TAIL, ST_WORD: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // segment outputs
  always_comb begin
    emit = 1'b0;
    seg  = '{key_level: 1'b0, duration_ms: dur.dot1, last_segment: 1'b0};
    unique case (state_q)
      ST_IDLE: emit = 1'b0;
      ST_MARK: begin
        emit             = 1'b1;
        seg.key_level    = 1'b1;
        seg.duration_ms  = pat_q[PatW-1] ? dur.dot3 : dur.dot1;
        seg.last_segment = (cnt_q == 3'd1) && !tail_q;
      end
      ST_GAP: emit = 1'b1;
      ST_TAIL: begin
        emit             = 1'b1;
        seg.duration_ms  = dur.dot3;
        seg.last_segment = 1'b1;
      end
      ST_WORD: begin
        emit             = 1'b1;
        seg.duration_ms  = dur.dot7;
        seg.last_segment = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (slot_free) begin
      out_valid_d = emit;
      out_d       = seg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[src/mkse_checker.sv]
// ----------------------------------------------------------------------------
// mkse_checker
// Port-level checks of the morse keyer segment encoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mkse_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           out_valid_o,
  input  wire logic           out_stall_i,
  input  wire mkse_pkg::out_t out_data_o
);
  import mkse_pkg::*;

  // a stalled transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  a_dur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.duration_ms >= 14'd30 && out_data_o.duration_ms <= 14'd8400)
    else $error("segment duration out of range");

  // element gap inside a character is one dot
  a_gap_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.key_level && !out_data_o.last_segment
      |-> out_data_o.duration_ms <= 14'd1200)
    else $error("inner gap longer than one dot");

  // tones never exceed a dash
  a_mark_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.key_level |-> out_data_o.duration_ms <= 14'd3600)
    else $error("tone longer than a dash");

endmodule

bind morse_keyer_segment_encoder mkse_checker u_mkse_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
